@@ design/rit_pkg.sv @@
// ----------------------------------------------------------------------------
// rit_pkg
// Shared constants and register codes for the radix integer to text converter.
// ----------------------------------------------------------------------------
package rit_pkg;

    // alphabet and digit limits
    localparam int MAX_BASE     = 16;
    localparam int MAX_DIGITS   = 32;
    localparam int SYMBOL_SLOTS = 16;

    // field widths
    localparam int NUMBER_W  = 32;
    localparam int CHAR_W    = 8;
    localparam int LENGTH_W  = 5;
    localparam int SYMBOLS_W = 64;
    localparam int COUNT_W   = 6;
    localparam int REM_W     = 4;
    localparam int CFG_IDX_W = 2;

    // dividend bits handled by the divider in one cycle
    localparam int BITS_PER_STEP = 8;
    localparam int STEPS_PER_DIGIT = NUMBER_W / BITS_PER_STEP;
    localparam int STEP_W = $clog2(STEPS_PER_DIGIT);

    // special characters
    localparam logic [CHAR_W-1:0] PLUS_CHAR  = 8'h2B;
    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHABET_LENGTH = 2'd0,
        CFG_SYMBOLS_LOW     = 2'd1,
        CFG_SYMBOLS_HIGH    = 2'd2
    } cfg_reg_t;

endpackage

@@ design/radix_integer_to_text.sv @@
// ----------------------------------------------------------------------------
// radix_integer_to_text
// Converts a signed 32-bit number to text in a programmable base of 2 to 16,
// one character per output transfer, most significant digit first.
// ----------------------------------------------------------------------------
// One number is converted at a time; in_stall stays high from the transfer
// until its last character has been loaded into the output register. After
// the transfer, the ST_CHECK state checks the alphabet (an invalid alphabet
// gives no output), then a shared restoring divider produces each digit,
// taking 8 dividend bits per cycle, and the digits are then played back
// from a 32-entry buffer at one character per cycle while out_stall is low.
// An output register lets the next number be taken while the last
// character is still waiting.
module radix_integer_to_text (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [rit_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rit_pkg::SYMBOLS_W-1:0]     cfg_data,
    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [rit_pkg::NUMBER_W-1:0] number,
    // output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [rit_pkg::CHAR_W-1:0]        character,
    output logic                              last_char
);
    import rit_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    state_t                 state_reg, state_next;

    logic [LENGTH_W-1:0]    alphabet_length_reg, alphabet_length_next;
    logic [SYMBOLS_W-1:0]   symbols_low_reg, symbols_low_next;
    logic [SYMBOLS_W-1:0]   symbols_high_reg, symbols_high_next;

    logic [NUMBER_W-1:0]    quo_reg, quo_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic                   sign_reg, sign_next;
    logic [COUNT_W-1:0]     digit_count_reg, digit_count_next;
    logic [COUNT_W-1:0]     rd_idx_reg, rd_idx_next;

    logic                   out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]      character_reg, character_next;
    logic                   last_char_reg, last_char_next;

    logic [CHAR_W-1:0]      digit_buffer [MAX_DIGITS];

    logic [2*SYMBOLS_W-1:0] symbols;
    logic                   alphabet_ok;
    logic [NUMBER_W-1:0]    quo_step;
    logic [REM_W-1:0]       rem_step;
    logic [CHAR_W-1:0]      digit_symbol;
    logic                   digit_wr;
    logic                   slot_free;
    logic [COUNT_W-1:0]     rd_addr;

    assign symbols = {symbols_high_reg, symbols_low_reg};

    // alphabet check: length range, no sign symbols, no duplicates
    always_comb
    begin
        logic [CHAR_W-1:0] sa;
        alphabet_ok = (alphabet_length_reg >= LENGTH_W'(2))
                   && (alphabet_length_reg <= LENGTH_W'(MAX_BASE))
                   && (alphabet_length_reg <= LENGTH_W'(SYMBOL_SLOTS));
        for (int a = 0; a < SYMBOL_SLOTS; a++)
        begin
            sa = symbols[a*CHAR_W +: CHAR_W];
            if (LENGTH_W'(a) < alphabet_length_reg)
            begin
                if (sa == PLUS_CHAR || sa == MINUS_CHAR)
                    alphabet_ok = 1'b0;
                for (int b = a + 1; b < SYMBOL_SLOTS; b++)
                begin
                    if (LENGTH_W'(b) < alphabet_length_reg
                        && symbols[b*CHAR_W +: CHAR_W] == sa)
                        alphabet_ok = 1'b0;
                end
            end
        end
    end

    // shared restoring divider: eight dividend bits per cycle, msb first
    always_comb
    begin
        logic [REM_W:0] trial;
        logic [REM_W-1:0] r;
        logic [BITS_PER_STEP-1:0] qbits;
        logic [BITS_PER_STEP-1:0] dbits;
        r = rem_reg;
        dbits = quo_reg[NUMBER_W-1 -: BITS_PER_STEP];
        qbits = '0;
        for (int i = BITS_PER_STEP - 1; i >= 0; i--)
        begin
            trial = {r, dbits[i]};
            if (trial >= alphabet_length_reg)
            begin
                qbits[i] = 1'b1;
                r = REM_W'(trial - alphabet_length_reg);
            end
            else
            begin
                r = REM_W'(trial);
            end
        end
        rem_step = r;
        quo_step = {quo_reg[NUMBER_W-BITS_PER_STEP-1:0], qbits};
    end

    assign digit_symbol = symbols[{rem_step, 3'b000} +: CHAR_W];
    assign digit_wr     = (state_reg == ST_DIVIDE)
                       && (step_reg == STEP_W'(STEPS_PER_DIGIT - 1));
    assign slot_free    = !out_valid_reg || !out_stall;
    assign rd_addr      = rd_idx_reg - COUNT_W'(1);

    // sequencer next state
    always_comb
    begin
        state_next           = state_reg;
        alphabet_length_next = alphabet_length_reg;
        symbols_low_next     = symbols_low_reg;
        symbols_high_next    = symbols_high_reg;
        quo_next             = quo_reg;
        rem_next             = rem_reg;
        step_next            = step_reg;
        sign_next            = sign_reg;
        digit_count_next     = digit_count_reg;
        rd_idx_next          = rd_idx_reg;
        out_valid_next       = out_valid_reg && out_stall;
        character_next       = character_reg;
        last_char_next       = last_char_reg;

        // configuration writes
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ALPHABET_LENGTH: alphabet_length_next = cfg_data[LENGTH_W-1:0];
                CFG_SYMBOLS_LOW:     symbols_low_next     = cfg_data;
                CFG_SYMBOLS_HIGH:    symbols_high_next    = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    sign_next  = number[NUMBER_W-1];
                    quo_next   = number[NUMBER_W-1] ? (NUMBER_W'(0) - NUMBER_W'(number))
                                                    : NUMBER_W'(number);
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (alphabet_ok)
                begin
                    rem_next         = '0;
                    step_next        = '0;
                    digit_count_next = '0;
                    state_next       = ST_DIVIDE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIVIDE:
            begin
                quo_next  = quo_step;
                rem_next  = rem_step;
                step_next = step_reg + STEP_W'(1);
                if (digit_wr)
                begin
                    rem_next         = '0;
                    digit_count_next = digit_count_reg + COUNT_W'(1);
                    if (quo_step == '0
                        || digit_count_reg == COUNT_W'(MAX_DIGITS - 1))
                    begin
                        rd_idx_next = digit_count_reg + COUNT_W'(1);
                        state_next  = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (sign_reg)
                    begin
                        character_next = MINUS_CHAR;
                        last_char_next = 1'b0;
                        sign_next      = 1'b0;
                    end
                    else
                    begin
                        character_next = digit_buffer[rd_addr[COUNT_W-2:0]];
                        last_char_next = (rd_idx_reg == COUNT_W'(1));
                        rd_idx_next    = rd_idx_reg - COUNT_W'(1);
                        if (rd_idx_reg == COUNT_W'(1))
                            state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, configuration and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            alphabet_length_reg <= '0;
            symbols_low_reg     <= '0;
            symbols_high_reg    <= '0;
            step_reg            <= '0;
            sign_reg            <= 1'b0;
            digit_count_reg     <= '0;
            rd_idx_reg          <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg           <= state_next;
            alphabet_length_reg <= alphabet_length_next;
            symbols_low_reg     <= symbols_low_next;
            symbols_high_reg    <= symbols_high_next;
            step_reg            <= step_next;
            sign_reg            <= sign_next;
            digit_count_reg     <= digit_count_next;
            rd_idx_reg          <= rd_idx_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        character_reg <= character_next;
        last_char_reg <= last_char_next;
    end

    // digit buffer, least significant digit first
    always_ff @(posedge clk)
    begin
        if (digit_wr)
            digit_buffer[digit_count_reg[COUNT_W-2:0]] <= digit_symbol;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign character = character_reg;
    assign last_char = last_char_reg;

`ifndef SYNTHESIS
    // a number is never taken while the previous one is still converting
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
    else $error("input taken twice without conversion in between");

    // the digit count never passes the buffer depth
    assert property (@(posedge clk) disable iff (!rst_n)
        digit_count_reg <= COUNT_W'(MAX_DIGITS))
    else $error("digit count beyond buffer depth");

    // a minus sign is never the final character
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && character == MINUS_CHAR) |-> !last_char)
    else $error("minus sign marked as last character");

    // a new character is only loaded once the old one has gone
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall && state_reg == ST_EMIT) |=> $stable(character))
    else $error("output overwritten while stalled");
`endif

endmodule
